/* rtl/stc_pkg.sv */
// Shared types and constants for the triggered scope capture core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package stc_pkg;

  // Sweep geometry
  localparam int SWEEP_DEPTH = 512;
  localparam int IDX_W       = $clog2(SWEEP_DEPTH + 1);
  localparam int WIDX_W      = 9;

  // Field widths
  localparam int SAMPLE_W  = 15;
  localparam int DEC_W     = 16;
  localparam int TIMEOUT_W = 18;
  localparam int TICK_W    = 20;
  localparam int CFG_W     = 18;
  localparam int CFG_IDX_W = 3;

  // Hysteresis below the trigger level, mV
  localparam logic signed [SAMPLE_W:0] HYST_MV = 16'sd100;

  localparam logic [TIMEOUT_W-1:0] AUTO_TIMEOUT_RST = 18'd4410;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DECIMATION    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_LEVEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_TIMEOUT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_XY_MODE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXTERNAL_MODE = 3'd4;

  // Restart causes
  localparam logic [1:0] CAUSE_NONE      = 2'd0;
  localparam logic [1:0] CAUSE_FREE_RUN  = 2'd1;
  localparam logic [1:0] CAUSE_TRIGGERED = 2'd2;
  localparam logic [1:0] CAUSE_TIMEOUT   = 2'd3;

  typedef enum logic [1:0] {
    TS_UNKNOWN = 2'd0,
    TS_LOW     = 2'd1,
    TS_HIGH    = 2'd2
  } trig_state_t;

  typedef struct packed {
    logic        fired;
    trig_state_t state;
  } trig_result_t;

endpackage

/* rtl/scope_triggered_capture_core.sv */
// Top level: sweep capture with decimation, edge trigger and auto restart.
// Result word registered the cycle after a tick is accepted; one tick per cycle
// while the output is not stalled. The sweep/tick/trigger update is a single pass
// of compares and increments between the accepting edge and the result register.
// Reset (rst, synchronous): sweep and tick counters cleared, trigger unknown,
// registers to defaults (auto timeout 4410), output register empty.
// Depends on stc_pkg and stc_schmitt.
`timescale 1ns / 1ps

module scope_triggered_capture_core import stc_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  // tick input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [SAMPLE_W-1:0]  x_sample,
  input  logic signed [SAMPLE_W-1:0]  y_sample,
  input  logic signed [SAMPLE_W-1:0]  trig_sample,
  input  logic                        trig_connected,
  // result output
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        sample_written,
  output logic [WIDX_W-1:0]           write_index,
  output logic signed [SAMPLE_W-1:0]  captured_x,
  output logic signed [SAMPLE_W-1:0]  captured_y,
  output logic                        sweep_full,
  output logic [1:0]                  restart_cause,
  output logic                        waiting
);

  localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(SWEEP_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SWEEP_DEPTH - 1);

  // configuration registers
  logic [DEC_W-1:0]           decimation;
  logic signed [SAMPLE_W-1:0] trigger_level;
  logic [TIMEOUT_W-1:0]       auto_timeout;
  logic                       xy_mode;
  logic                       external_mode;

  // state
  logic [IDX_W-1:0]  sweep_index, sweep_index_next;
  logic [TICK_W-1:0] tick_count, tick_count_next;
  trig_state_t       trig_state;

  logic                       accept;
  logic                       filling;
  logic [TICK_W-1:0]          tick_inc;
  logic                       wr;
  logic                       full;
  logic                       in_wait;
  logic                       free_run;
  logic [TICK_W-1:0]          wait_tick;
  logic                       wait_restart;
  logic signed [SAMPLE_W-1:0] gate;
  trig_result_t               trig;
  logic [1:0]                 cause;
  logic [IDX_W-1:0]           idx_after_fill;
  logic [IDX_W+WIDX_W-1:0]    idx_wide;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      decimation    <= '0;
      trigger_level <= '0;
      auto_timeout  <= AUTO_TIMEOUT_RST;
      xy_mode       <= 1'b0;
      external_mode <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DECIMATION:    decimation    <= cfg_data[DEC_W-1:0];
        REG_TRIGGER_LEVEL: trigger_level <= cfg_data[SAMPLE_W-1:0];
        REG_AUTO_TIMEOUT:  auto_timeout  <= cfg_data[TIMEOUT_W-1:0];
        REG_XY_MODE:       xy_mode       <= cfg_data[0];
        REG_EXTERNAL_MODE: external_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // fill phase
  assign filling        = sweep_index < DEPTH_IDX;
  assign tick_inc       = tick_count + TICK_W'(1);
  assign wr             = filling && (tick_inc > TICK_W'(decimation));
  assign full           = wr && (sweep_index == LAST_IDX);
  assign idx_after_fill = wr ? sweep_index + IDX_W'(1) : sweep_index;
  assign idx_wide       = {{WIDX_W{1'b0}}, sweep_index};

  // wait phase; a store this tick starts the wait with the tick count at one
  assign in_wait      = idx_after_fill >= DEPTH_IDX;
  assign free_run     = xy_mode || (external_mode && !trig_connected);
  assign wait_restart = wr || (!filling && tick_count == '0);
  assign wait_tick    = wr ? TICK_W'(1) : tick_inc;
  assign gate         = external_mode ? trig_sample : x_sample;

  stc_schmitt u_schmitt (
    .gate    (gate),
    .level   (trigger_level),
    .state   (trig_state),
    .restart (wait_restart),
    .result  (trig)
  );

  always_comb begin
    cause            = CAUSE_NONE;
    sweep_index_next = idx_after_fill;
    tick_count_next  = filling ? (wr ? '0 : tick_inc) : tick_count;
    if (in_wait) begin
      if (free_run) begin
        cause = CAUSE_FREE_RUN;
      end else begin
        tick_count_next = wait_tick;
        if (trig.fired) cause = CAUSE_TRIGGERED;
        else if (wait_tick >= TICK_W'(auto_timeout)) cause = CAUSE_TIMEOUT;
      end
      if (cause != CAUSE_NONE) begin
        sweep_index_next = '0;
        tick_count_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_index <= '0;
      tick_count  <= '0;
      trig_state  <= TS_UNKNOWN;
    end else if (accept) begin
      sweep_index <= sweep_index_next;
      tick_count  <= tick_count_next;
      if (in_wait && !free_run) trig_state <= trig.state;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_written <= wr;
      write_index    <= wr ? idx_wide[WIDX_W-1:0] : '0;
      captured_x     <= wr ? x_sample : '0;
      captured_y     <= wr ? y_sample : '0;
      sweep_full     <= full;
      restart_cause  <= cause;
      waiting        <= sweep_index_next >= DEPTH_IDX;
    end
  end

endmodule

/* rtl/stc_schmitt.sv */
// Schmitt trigger next-state logic with rising-edge fire detect.
// Depends on stc_pkg.
`timescale 1ns / 1ps

module stc_schmitt import stc_pkg::*; (
  input  logic signed [SAMPLE_W-1:0] gate,
  input  logic signed [SAMPLE_W-1:0] level,
  input  trig_state_t                state,
  input  logic                       restart,
  output trig_result_t               result
);

  logic signed [SAMPLE_W:0] gate_ext;
  logic signed [SAMPLE_W:0] level_ext;
  logic signed [SAMPLE_W:0] low_bound;
  logic                     hi;
  logic                     lo;
  trig_state_t              cur;

  assign gate_ext  = {gate[SAMPLE_W-1], gate};
  assign level_ext = {level[SAMPLE_W-1], level};
  assign low_bound = level_ext - HYST_MV;
  assign hi        = gate_ext >= level_ext;
  assign lo        = gate_ext <= low_bound;
  // a fresh wait forgets the old edge history
  assign cur       = restart ? TS_UNKNOWN : state;

  always_comb begin
    result.fired = 1'b0;
    result.state = cur;
    case (cur)
      TS_LOW: begin
        if (hi) begin
          result.state = TS_HIGH;
          result.fired = 1'b1;
        end
      end
      TS_HIGH: begin
        if (lo) result.state = TS_LOW;
      end
      default: begin
        if (hi) result.state = TS_HIGH;
        else if (lo) result.state = TS_LOW;
        else result.state = TS_UNKNOWN;
      end
    endcase
  end

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for scope_triggered_capture_core: directed trigger/sweep cases,
// then random ticks under two idle patterns, each word checked against an in-bench model.
// Depends on rtl/stc_pkg.sv and rtl/scope_triggered_capture_core.sv.
`timescale 1ns / 1ps

module tb_top;
  import stc_pkg::*;

  typedef struct {
    logic                       written;
    logic [WIDX_W-1:0]          widx;
    logic signed [SAMPLE_W-1:0] cx;
    logic signed [SAMPLE_W-1:0] cy;
    logic                       full;
    logic [1:0]                 cause;
    logic                       waiting;
  } capture_word_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_W-1:0]           cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] x_sample = '0;
  logic signed [SAMPLE_W-1:0] y_sample = '0;
  logic signed [SAMPLE_W-1:0] trig_sample = '0;
  logic                       trig_connected = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       sample_written;
  logic [WIDX_W-1:0]          write_index;
  logic signed [SAMPLE_W-1:0] captured_x;
  logic signed [SAMPLE_W-1:0] captured_y;
  logic                       sweep_full;
  logic [1:0]                 restart_cause;
  logic                       waiting;

  // Capture model state and its copy of the registers
  int unsigned                sweep_pos = 0;
  logic [TICK_W-1:0]          tick_cnt = '0;
  trig_state_t                trig_st = TS_UNKNOWN;
  logic [DEC_W-1:0]           dec_reg = '0;
  logic signed [SAMPLE_W-1:0] level_reg = '0;
  logic [TIMEOUT_W-1:0]       timeout_reg = AUTO_TIMEOUT_RST;
  logic                       xy_reg = 1'b0;
  logic                       ext_reg = 1'b0;

  capture_word_t pending_words[$];
  capture_word_t last_word;
  int src_idle_pct = 32;
  int snk_stall_pct = 56;
  int n_fail = 0;

  scope_triggered_capture_core i_dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < snk_stall_pct);
  end

  function automatic capture_word_t predict_capture(input logic signed [SAMPLE_W-1:0] xs, ys,
                                                    ts, input logic conn);
    capture_word_t w;
    int g;
    logic hi, lo, fired;
    w = '{default: '0};
    fired = 1'b0;
    if (sweep_pos < SWEEP_DEPTH) begin
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt > dec_reg) begin
        tick_cnt = '0;
        w.written = 1'b1;
        w.widx = WIDX_W'(sweep_pos);
        w.cx = xs;
        w.cy = ys;
        sweep_pos++;
        if (sweep_pos >= SWEEP_DEPTH) w.full = 1'b1;
      end
    end
    if (sweep_pos >= SWEEP_DEPTH) begin
      if (xy_reg || (ext_reg && !conn)) begin
        sweep_pos = 0;
        tick_cnt = '0;
        w.cause = CAUSE_FREE_RUN;
      end else begin
        // a fresh wait forgets the old trigger state
        if (tick_cnt == 0) trig_st = TS_UNKNOWN;
        tick_cnt = tick_cnt + 1'b1;
        g = ext_reg ? int'(ts) : int'(xs);
        hi = (g >= int'(level_reg));
        lo = (g <= int'(level_reg) - int'(HYST_MV));
        case (trig_st)
          TS_LOW: begin
            if (hi) begin
              trig_st = TS_HIGH;
              fired = 1'b1;
            end
          end
          TS_HIGH: begin
            if (lo) trig_st = TS_LOW;
          end
          default: begin
            if (hi) trig_st = TS_HIGH;
            else if (lo) trig_st = TS_LOW;
          end
        endcase
        if (fired) w.cause = CAUSE_TRIGGERED;
        else if (tick_cnt >= timeout_reg) w.cause = CAUSE_TIMEOUT;
        if (w.cause != CAUSE_NONE) begin
          sweep_pos = 0;
          tick_cnt = '0;
        end
      end
    end
    w.waiting = (sweep_pos >= SWEEP_DEPTH);
    return w;
  endfunction

  // 1 in 5 spans the full 15-bit code range, the rest stay in the +/-12 V band
  function automatic int rand_mv();
    if ($urandom_range(4) == 0) return int'($urandom_range(32767)) - 16384;
    return int'($urandom_range(24000)) - 12000;
  endfunction

  task automatic check_field(input string field, input logic signed [31:0] exp_v, act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", field, exp_v, act_v);
      n_fail++;
    end
  endtask

  always @(negedge clk) begin
    capture_word_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("result word with nothing expected");
        n_fail++;
      end else begin
        w = pending_words.pop_front();
        check_field("sample_written", w.written, sample_written);
        check_field("write_index", w.widx, write_index);
        check_field("captured_x", w.cx, captured_x);
        check_field("captured_y", w.cy, captured_y);
        check_field("sweep_full", w.full, sweep_full);
        check_field("restart_cause", w.cause, restart_cause);
        check_field("waiting", w.waiting, waiting);
      end
    end
  end

  task automatic send_tick(input int xs, ys, ts, input logic conn);
    bit taken;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    x_sample <= SAMPLE_W'(xs);
    y_sample <= SAMPLE_W'(ys);
    trig_sample <= SAMPLE_W'(ts);
    trig_connected <= conn;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    last_word = predict_capture(SAMPLE_W'(xs), SAMPLE_W'(ys), SAMPLE_W'(ts), conn);
    pending_words.push_back(last_word);
  endtask

  task automatic drain_words();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(data);
    @(posedge clk);
    case (idx)
      REG_DECIMATION:    dec_reg = DEC_W'(data);
      REG_TRIGGER_LEVEL: level_reg = SAMPLE_W'(data);
      REG_AUTO_TIMEOUT:  timeout_reg = TIMEOUT_W'(data);
      REG_XY_MODE:       xy_reg = data[0];
      REG_EXTERNAL_MODE: ext_reg = data[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int dec, level, timeout, input logic xy, ext);
    write_reg(REG_DECIMATION, dec);
    write_reg(REG_TRIGGER_LEVEL, level);
    write_reg(REG_AUTO_TIMEOUT, timeout);
    write_reg(REG_XY_MODE, xy);
    write_reg(REG_EXTERNAL_MODE, ext);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // runs ticks with a fixed trigger input until the sweep completes
  task automatic fill_sweep(input int xs, ts, input logic conn);
    do begin
      send_tick(xs, rand_mv(), ts, conn);
    end while (!last_word.full);
  endtask

  task automatic test_sample_extremes();
    set_config(0, 0, AUTO_TIMEOUT_RST, 1'b0, 1'b0);
    send_tick(-16384, 16383, -16384, 1'b0);
    send_tick(16383, -16384, 16383, 1'b1);
    send_tick(-12000, 12000, 0, 1'b1);
    send_tick(12000, -12000, -1, 1'b0);
    send_tick(0, -1, 12000, 1'b1);
    drain_words();
    // widest decimation: no write for these ticks
    set_config(65535, 0, AUTO_TIMEOUT_RST, 1'b0, 1'b0);
    repeat (6) send_tick(rand_mv(), rand_mv(), rand_mv(), 1'b1);
    drain_words();
  endtask

  // the fire lands on the fourth wait tick, which is also the timeout tick
  task automatic test_trigger_hysteresis();
    set_config(0, 500, 4, 1'b0, 1'b0);
    fill_sweep(700, 0, 1'b1);         // unknown -> high, no fire
    send_tick(450, rand_mv(), 0, 1'b1);
    send_tick(400, rand_mv(), 0, 1'b1); // re-arm at level - 100
    send_tick(500, rand_mv(), 0, 1'b1); // fires
    drain_words();
  endtask

  task automatic test_mode_change_in_wait();
    set_config(0, 10000, 262143, 1'b0, 1'b0);
    fill_sweep(0, 0, 1'b1);
    repeat (3) send_tick(0, rand_mv(), 0, 1'b1);
    drain_words();
    set_config(0, 10000, 262143, 1'b1, 1'b0);
    send_tick(0, rand_mv(), 0, 1'b1);
    drain_words();
  endtask

  // random register settings per segment; trigger input mostly a triangle
  // wave swinging through the trigger level
  task automatic test_random_traffic(input int n_ticks);
    int sent, seg_len, r, dec, lvl, tmo, span, pos, dir, stepv, g;
    sent = 0;
    while (sent < n_ticks) begin
      drain_words();
      r = $urandom_range(99);
      if (r < 60) dec = 0;
      else if (r < 85) dec = $urandom_range(1, 3);
      else if (r < 97) dec = $urandom_range(4, 12);
      else dec = $urandom_range(13, 65535);
      r = $urandom_range(99);
      if (r < 70) lvl = int'($urandom_range(20000)) - 10000;
      else if (r < 85) lvl = int'($urandom_range(400)) - 200;
      else lvl = int'($urandom_range(32767)) - 16384;
      r = $urandom_range(99);
      if (r < 10) tmo = 0;
      else if (r < 50) tmo = $urandom_range(1, 60);
      else if (r < 85) tmo = $urandom_range(61, 800);
      else tmo = $urandom_range(262143);
      set_config(dec, lvl, tmo, $urandom_range(9) == 0, $urandom_range(2) == 0);
      span = $urandom_range(50, 3000);
      stepv = $urandom_range(10, span / 2);
      pos = lvl - span;
      dir = 1;
      seg_len = $urandom_range(20, 60);
      if (seg_len > n_ticks - sent) seg_len = n_ticks - sent;
      repeat (seg_len) begin
        r = $urandom_range(99);
        if (r < 70) begin
          pos += dir * stepv;
          if (pos >= lvl + span) dir = -1;
          if (pos <= lvl - span) dir = 1;
          g = pos;
        end else if (r < 85) begin
          case ($urandom_range(5))
            0: g = lvl;
            1: g = lvl - 1;
            2: g = lvl + 1;
            3: g = lvl - 99;
            4: g = lvl - 100;
            default: g = lvl - 101;
          endcase
        end else begin
          g = rand_mv();
        end
        if (g > 16383) g = 16383;
        if (g < -16384) g = -16384;
        if (ext_reg) send_tick(rand_mv(), rand_mv(), g, $urandom_range(19) != 0);
        else send_tick(g, rand_mv(), rand_mv(), $urandom_range(19) != 0);
      end
      sent += seg_len;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_sample_extremes();
    test_trigger_hysteresis();
    test_mode_change_in_wait();
    src_idle_pct = 56;
    snk_stall_pct = 32;
    test_random_traffic(100);
    src_idle_pct = 0;
    snk_stall_pct = 0;
    test_random_traffic(100);
    drain_words();
    repeat (4) @(posedge clk);
    if (n_fail == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* scope_triggered_capture_core.f */
rtl/stc_pkg.sv
rtl/stc_schmitt.sv
rtl/scope_triggered_capture_core.sv
tb/tb_top.sv
